// File: hw/rtl/rrs_pkg.sv
// rectangle region store: shared types, constants and codes
// used by rrs_ctrl, rrs_datapath and rectangle_region_store_top; no dependencies
`default_nettype none
package rrs_pkg;

  localparam int MAX_BOXES       = 64;
  localparam int IDX_W           = $clog2(MAX_BOXES);
  localparam int CNT_W           = $clog2(MAX_BOXES + 1);
  localparam int POINT_FRAC_BITS = 8;
  localparam int POINT_W         = 41;
  // compare width for point tests: box edge end (33 bits) scaled, plus a guard bit
  localparam int CMP_W = ((33 + POINT_FRAC_BITS > POINT_W) ? 33 + POINT_FRAC_BITS : POINT_W) + 1;

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_SUBTRACT = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] top;
    logic [30:0] width;
    logic [30:0] height;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic add_wr;
    logic sub_start;
    logic rd;
    logic calc;
    logic put;
    logic sub_commit;
    logic qry_start;
    logic qry_chk;
    logic clear;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic box_empty;
    logic idx_done;
    logic fail;
    logic hit;
    logic last_piece;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/rrs_ctrl.sv
// rectangle region store: sequencing state machine
// depends on rrs_pkg; drives rrs_datapath through cmd_t, reads sts_t
`default_nettype none
module rrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output rrs_pkg::cmd_t cmd,
  input  rrs_pkg::sts_t sts
);
  import rrs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_ADD_WR   = 9'b000000100,
    S_SUB_RD   = 9'b000001000,
    S_SUB_CALC = 9'b000010000,
    S_SUB_PUT  = 9'b000100000,
    S_QRY_RD   = 9'b001000000,
    S_QRY_CHK  = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ADD: begin
            state_next = sts.box_empty ? S_FINISH : S_ADD_WR;
          end
          OP_SUBTRACT: begin
            if (sts.box_empty) begin
              state_next = S_FINISH;
            end else begin
              cmd.sub_start = 1'b1;
              state_next    = S_SUB_RD;
            end
          end
          OP_CONTAINS: begin
            cmd.qry_start = 1'b1;
            state_next    = S_QRY_RD;
          end
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_SUB_RD: begin
        if (sts.idx_done || sts.fail) begin
          cmd.sub_commit = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_SUB_CALC;
        end
      end
      S_SUB_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_SUB_PUT;
      end
      S_SUB_PUT: begin
        cmd.put = 1'b1;
        if (sts.last_piece) begin
          state_next = S_SUB_RD;
        end
      end
      S_QRY_RD: begin
        if (sts.idx_done || sts.hit) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_QRY_CHK;
        end
      end
      S_QRY_CHK: begin
        cmd.qry_chk = 1'b1;
        state_next  = S_QRY_RD;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/rrs_datapath.sv
// rectangle region store: box memory, counters, intersection and point test, result register
// depends on rrs_pkg; commanded by rrs_ctrl
`default_nettype none
module rrs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rrs_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                       s_tuser,
  input  rrs_pkg::cmd_t                    cmd,
  output rrs_pkg::sts_t                    sts,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [rrs_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import rrs_pkg::*;

  localparam logic signed [33:0] EDGE_MAX = 34'sd2147483647;

  // captured item
  op_t                      op;
  logic signed [31:0]       in_x, in_y, in_w, in_h;
  logic signed [POINT_W-1:0] in_px, in_py;

  // region state
  logic [CNT_W-1:0] live_count;
  logic             live_bank;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] n;
  logic [1:0]       piece;
  logic             fail;
  logic             hit;

  // two banks of boxes
  logic [$bits(box_t)-1:0] mem [2*MAX_BOXES];
  box_t                    rd_box;

  // registered intersection of stored box and cut
  logic signed [31:0] c_x0, c_y0, c_ix0, c_iy0;
  logic signed [32:0] c_x1, c_y1, c_ix1, c_iy1;
  logic [30:0]        c_w, c_h;
  logic               c_ovl;

  logic               out_valid;
  status_t            out_status;
  logic               out_hit;
  logic [CNT_W-1:0]   out_count;

  logic box_empty;
  assign box_empty = in_w[31] || (in_w == '0) || in_h[31] || (in_h == '0);

  // intersection of the box just read with the cut
  logic signed [32:0] b_x1, b_y1, s_x1, s_y1, i_x1, i_y1;
  logic signed [31:0] b_x0, b_y0, i_x0, i_y0;
  always_comb begin
    b_x0 = $signed(rd_box.left);
    b_y0 = $signed(rd_box.top);
    b_x1 = $signed({rd_box.left[31], rd_box.left}) + $signed({2'b00, rd_box.width});
    b_y1 = $signed({rd_box.top[31], rd_box.top}) + $signed({2'b00, rd_box.height});
    s_x1 = $signed({in_x[31], in_x}) + $signed({2'b00, in_w[30:0]});
    s_y1 = $signed({in_y[31], in_y}) + $signed({2'b00, in_h[30:0]});
    i_x0 = (b_x0 > in_x) ? b_x0 : in_x;
    i_y0 = (b_y0 > in_y) ? b_y0 : in_y;
    i_x1 = (b_x1 < s_x1) ? b_x1 : s_x1;
    i_y1 = (b_y1 < s_y1) ? b_y1 : s_y1;
  end

  // remainder piece selected by the piece counter
  logic signed [33:0] p_x, p_y, p_w, p_h;
  logic               p_ok;
  always_comb begin
    p_x = $signed({{2{c_x0[31]}}, c_x0});
    p_y = $signed({{2{c_y0[31]}}, c_y0});
    p_w = $signed({3'b000, c_w});
    p_h = $signed({3'b000, c_h});
    if (c_ovl) begin
      unique case (piece)
        2'd0: begin  // top
          p_h = $signed({{2{c_iy0[31]}}, c_iy0}) - $signed({{2{c_y0[31]}}, c_y0});
        end
        2'd1: begin  // bottom
          p_y = $signed({c_iy1[32], c_iy1});
          p_h = $signed({c_y1[32], c_y1}) - $signed({c_iy1[32], c_iy1});
        end
        2'd2: begin  // left
          p_y = $signed({{2{c_iy0[31]}}, c_iy0});
          p_w = $signed({{2{c_ix0[31]}}, c_ix0}) - $signed({{2{c_x0[31]}}, c_x0});
          p_h = $signed({c_iy1[32], c_iy1}) - $signed({{2{c_iy0[31]}}, c_iy0});
        end
        2'd3: begin  // right
          p_x = $signed({c_ix1[32], c_ix1});
          p_y = $signed({{2{c_iy0[31]}}, c_iy0});
          p_w = $signed({c_x1[32], c_x1}) - $signed({c_ix1[32], c_ix1});
          p_h = $signed({c_iy1[32], c_iy1}) - $signed({{2{c_iy0[31]}}, c_iy0});
        end
        default: ;
      endcase
    end
    p_ok = (p_w > 34'sd0) && (p_h > 34'sd0) && (p_x <= EDGE_MAX) && (p_y <= EDGE_MAX);
  end

  // point test against the box just read
  logic signed [CMP_W-1:0] lo_x, lo_y, hi_x, hi_y, pt_x, pt_y;
  logic                    pt_in;
  always_comb begin
    lo_x  = $signed({{(CMP_W-32){rd_box.left[31]}}, rd_box.left}) <<< POINT_FRAC_BITS;
    lo_y  = $signed({{(CMP_W-32){rd_box.top[31]}}, rd_box.top}) <<< POINT_FRAC_BITS;
    hi_x  = $signed({{(CMP_W-33){b_x1[32]}}, b_x1}) <<< POINT_FRAC_BITS;
    hi_y  = $signed({{(CMP_W-33){b_y1[32]}}, b_y1}) <<< POINT_FRAC_BITS;
    pt_x  = $signed({{(CMP_W-POINT_W){in_px[POINT_W-1]}}, in_px});
    pt_y  = $signed({{(CMP_W-POINT_W){in_py[POINT_W-1]}}, in_py});
    pt_in = (pt_x >= lo_x) && (pt_y >= lo_y) && (pt_x < hi_x) && (pt_y < hi_y);
  end

  // single write port
  logic                     wr_en;
  logic [IDX_W:0]           wr_addr;
  box_t                     wr_box;
  logic                     add_full, put_full;
  assign add_full = (live_count >= CNT_W'(MAX_BOXES));
  assign put_full = (n >= CNT_W'(MAX_BOXES));
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {live_bank, live_count[IDX_W-1:0]};
    wr_box  = '{left: in_x, top: in_y, width: in_w[30:0], height: in_h[30:0]};
    if (cmd.add_wr) begin
      wr_en = !add_full;
    end else if (cmd.put) begin
      wr_en   = p_ok && !put_full;
      wr_addr = {~live_bank, n[IDX_W-1:0]};
      wr_box  = '{left: p_x[31:0], top: p_y[31:0], width: p_w[30:0], height: p_h[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_box;
    end
    if (cmd.rd) begin
      rd_box <= mem[{live_bank, idx[IDX_W-1:0]}];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op    <= op_t'(s_tuser);
      in_x  <= $signed(s_tdata[31:0]);
      in_y  <= $signed(s_tdata[63:32]);
      in_w  <= $signed(s_tdata[95:64]);
      in_h  <= $signed(s_tdata[127:96]);
      in_px <= $signed(s_tdata[168:128]);
      in_py <= $signed(s_tdata[209:169]);
    end
    if (cmd.calc) begin
      c_x0  <= b_x0;
      c_y0  <= b_y0;
      c_x1  <= b_x1;
      c_y1  <= b_y1;
      c_ix0 <= i_x0;
      c_iy0 <= i_y0;
      c_ix1 <= i_x1;
      c_iy1 <= i_y1;
      c_w   <= rd_box.width;
      c_h   <= rd_box.height;
      c_ovl <= !(($signed({i_x0[31], i_x0}) >= i_x1) || ($signed({i_y0[31], i_y0}) >= i_y1));
    end
    if (cmd.finish) begin
      out_status <= (box_empty && (op == OP_ADD || op == OP_SUBTRACT)) ? ST_EMPTY :
                    fail ? ST_NO_SPACE : ST_DONE;
      out_hit    <= hit;
      out_count  <= live_count;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      live_bank  <= 1'b0;
      idx        <= '0;
      n          <= '0;
      piece      <= '0;
      fail       <= 1'b0;
      hit        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cap) begin
        fail <= 1'b0;
        hit  <= 1'b0;
      end
      if (cmd.add_wr) begin
        if (add_full) begin
          fail <= 1'b1;
        end else begin
          live_count <= live_count + 1'b1;
        end
      end
      if (cmd.sub_start) begin
        idx <= '0;
        n   <= '0;
      end
      if (cmd.qry_start) begin
        idx <= '0;
      end
      if (cmd.calc) begin
        piece <= '0;
      end
      if (cmd.put) begin
        if (p_ok) begin
          if (put_full) begin
            fail <= 1'b1;
          end else begin
            n <= n + 1'b1;
          end
        end
        piece <= piece + 1'b1;
        if (sts.last_piece) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.sub_commit && !fail) begin
        live_bank  <= ~live_bank;
        live_count <= n;
      end
      if (cmd.qry_chk) begin
        idx <= idx + 1'b1;
        if (pt_in) begin
          hit <= 1'b1;
        end
      end
      if (cmd.clear) begin
        live_count <= '0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op         = op;
    sts.box_empty  = box_empty;
    sts.idx_done   = (idx >= live_count);
    sts.fail       = fail;
    sts.hit        = hit;
    sts.last_piece = !c_ovl || (piece == 2'd3);
    sts.out_busy   = out_valid && !m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-3-CNT_W){1'b0}}, out_count, out_hit, out_status};

endmodule
`default_nettype wire

// File: hw/rtl/rectangle_region_store_top.sv
// rectangle region store, top level: joins rrs_ctrl and rrs_datapath
// depends on rrs_pkg, rrs_ctrl, rrs_datapath
`default_nettype none
// Keeps a region as a list of up to 64 rectangles (left, top, width, height)
// and takes one command item at a time: add appends a box, subtract cuts a
// box out of the region (each overlapped box is replaced by its top, bottom,
// left and right remainders, written into the other memory bank, and the
// banks swap only if everything fit), contains tests a fixed-point point with
// 8 fraction bits against the boxes with half-open edges, clear empties the
// list. Every item gives exactly one result item: status, hit and the box
// count afterwards. The box memory is walked one entry at a time: contains
// reads and checks the boxes in turn and stops on the first hit, subtract
// gives each stored box one read, one compute and one write slot per
// remainder piece. The finishing state also waits while the previous
// result item is still unaccepted. No clearing pass is needed after reset.
// A new item is taken only once the previous one has left the sequencer;
// the result register lets the sink stall without losing it.
module rectangle_region_store_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // box_x[31:0], box_y[63:32], box_width[95:64], box_height[127:96],
  // point_x[168:128], point_y[209:169], zero pad above
  input  logic [rrs_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[1:0], hit[2], box_count[9:3], zero pad above
  output logic [rrs_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // box memory, arithmetic and result register
  rrs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  // the reported count never exceeds the list size
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:3] <= 7'(MAX_BOXES)))
    else $error("box count above list size");

  // only one item in the sequencer at a time
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item taken while busy");

  // a hit only comes with a done status
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_DONE))
    else $error("hit with non-done status");

endmodule
`default_nettype wire
